FILE: rtl/vector_matrix_multiply_assert.svh
// Assertion macros shared by the vector-matrix multiply RTL.
`ifndef VECTOR_MATRIX_MULTIPLY_ASSERT_SVH
`define VECTOR_MATRIX_MULTIPLY_ASSERT_SVH

`ifndef SYNTH
`define VMM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VMM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VMM_ASSERT(lbl, clk, rst_n, prop, msg)
`define VMM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/vmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vmm_pkg;

    localparam int MAX_COLS_DEF = 256;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 48;
    localparam int IDX_W     = 8;
    localparam int ROW_CNT_W = 11;
    localparam int COL_CNT_W = 9;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    // Register select is bit 2 of the byte address.
    localparam int          REG_SEL_BIT   = 2;
    localparam logic        REG_ROW_COUNT = 1'b0;
    localparam logic        REG_COL_COUNT = 1'b1;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic pass_last;
    } vmm_flags_t;

endpackage

`default_nettype wire

FILE: rtl/vector_matrix_multiply.sv
// Channel   Handshake            Beat contents
// input     in_valid/in_ready    vec_elem, mat_elem (signed Q8.8)
// output    out_valid/out_ready  col_sum (Q32.16), col_index, pass_last
// config    APB psel/penable     row_count at 0x0, col_count at 0x4
//
// The front takes one beat per cycle into a two-entry queue while it has room; the back
// handles each beat as a read and then a write of the column accumulator memory, and
// takes the next beat only after the write. Reset sets both counts to 1 and the pass to its
// start; the accumulators need no clearing. A stalled output holds the back only on
// last-row beats, while the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module vector_matrix_multiply #(
    parameter int MAX_COLS = vmm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = vmm_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [vmm_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [vmm_pkg::APB_W-1:0]           pwdata,
    output logic [vmm_pkg::APB_W-1:0]                prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [vmm_pkg::ELEM_W-1:0]   vec_elem,
    input  wire logic signed [vmm_pkg::ELEM_W-1:0]   mat_elem,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [vmm_pkg::SUM_W-1:0]         col_sum,
    output logic [vmm_pkg::IDX_W-1:0]                col_index,
    output logic                                     pass_last
);
    import vmm_pkg::*;

    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int FLAGS_W = $bits(vmm_flags_t);
    localparam int Q_W     = PROD_W + COL_W + FLAGS_W;

    logic                     fq_valid;
    logic                     fq_ready;
    logic signed [PROD_W-1:0] fq_prod;
    logic [COL_W-1:0]         fq_col;
    vmm_flags_t               fq_flags;
    logic [Q_W-1:0]           fq_data;
    logic                     qb_valid;
    logic                     qb_ready;
    logic [Q_W-1:0]           qb_data;
    logic signed [PROD_W-1:0] qb_prod;
    logic [COL_W-1:0]         qb_col;
    vmm_flags_t               qb_flags;

    assign fq_data = {fq_prod, fq_col, fq_flags};
    assign {qb_prod, qb_col, qb_flags} = qb_data;

    vmm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .COL_W    (COL_W),
        .ROW_W    (ROW_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .vec_elem (vec_elem),
        .mat_elem (mat_elem),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_prod   (fq_prod),
        .q_col    (fq_col),
        .q_flags  (fq_flags)
    );

    vmm_queue #(
        .DATA_W (Q_W),
        .DEPTH  (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    vmm_back #(
        .MAX_COLS (MAX_COLS),
        .COL_W    (COL_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_prod    (qb_prod),
        .q_col     (qb_col),
        .q_flags   (qb_flags),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .col_sum   (col_sum),
        .col_index (col_index),
        .pass_last (pass_last)
    );

endmodule

`default_nettype wire

FILE: rtl/vmm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vmm_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output logic [DATA_W-1:0]      rd_data
);
    import vmm_pkg::*;

    `include "vector_matrix_multiply_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `VMM_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count above depth")

endmodule

`default_nettype wire

FILE: rtl/vmm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vmm_front #(
    parameter int MAX_COLS = vmm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = vmm_pkg::MAX_ROWS_DEF,
    parameter int COL_W    = 8,
    parameter int ROW_W    = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [vmm_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [vmm_pkg::APB_W-1:0]           pwdata,
    output logic [vmm_pkg::APB_W-1:0]                prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [vmm_pkg::ELEM_W-1:0]   vec_elem,
    input  wire logic signed [vmm_pkg::ELEM_W-1:0]   mat_elem,
    output logic                                     q_valid,
    input  wire logic                                q_ready,
    output logic signed [vmm_pkg::PROD_W-1:0]        q_prod,
    output logic [COL_W-1:0]                         q_col,
    output vmm_pkg::vmm_flags_t                      q_flags
);
    import vmm_pkg::*;

    `include "vector_matrix_multiply_assert.svh"

    logic [ROW_CNT_W-1:0] row_count_reg;
    logic [COL_CNT_W-1:0] col_count_reg;
    logic [ROW_W-1:0]     row_pos_reg;
    logic [ROW_W-1:0]     row_pos_next;
    logic [COL_W-1:0]     col_pos_reg;
    logic [COL_W-1:0]     col_pos_next;
    logic [ROW_W-1:0]     rows_m1;
    logic [COL_W-1:0]     cols_m1;
    logic                 cfg_wr;
    logic                 accept;
    logic                 last_row;
    logic                 last_col;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[REG_SEL_BIT] == REG_COL_COUNT)
        begin
            prdata = APB_W'(col_count_reg);
        end
        else
        begin
            prdata = APB_W'(row_count_reg);
        end
    end

    // Out-of-range counts are clamped to the supported range.
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_m1 = '0;
        end
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
        begin
            rows_m1 = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            rows_m1 = ROW_W'(row_count_reg - 1'b1);
        end
        if (col_count_reg == '0)
        begin
            cols_m1 = '0;
        end
        else if (32'(col_count_reg) > 32'(MAX_COLS))
        begin
            cols_m1 = COL_W'(MAX_COLS - 1);
        end
        else
        begin
            cols_m1 = COL_W'(col_count_reg - 1'b1);
        end
    end

    assign last_row = (row_pos_reg == rows_m1);
    assign last_col = (col_pos_reg == cols_m1);
    assign accept   = in_valid && q_ready;

    assign in_ready          = q_ready;
    assign q_valid           = in_valid;
    assign q_prod            = PROD_W'(vec_elem) * PROD_W'(mat_elem);
    assign q_col             = col_pos_reg;
    assign q_flags.first_row = (row_pos_reg == '0);
    assign q_flags.last_row  = last_row;
    assign q_flags.pass_last = last_row && last_col;

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_wr)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + 1'b1;
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_CNT_W'(1);
            col_count_reg <= COL_CNT_W'(1);
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
        end
        else
        begin
            if (cfg_wr && (paddr[REG_SEL_BIT] == REG_ROW_COUNT))
            begin
                row_count_reg <= pwdata[ROW_CNT_W-1:0];
            end
            if (cfg_wr && (paddr[REG_SEL_BIT] == REG_COL_COUNT))
            begin
                col_count_reg <= pwdata[COL_CNT_W-1:0];
            end
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    `VMM_ASSERT(a_cfg_restart, clk, rst_n, cfg_wr |=> row_pos_reg == '0 && col_pos_reg == '0, "register write did not restart the pass")
    `VMM_ASSERT(a_pass_wrap, clk, rst_n, accept && last_row && last_col && !cfg_wr |=> row_pos_reg == '0 && col_pos_reg == '0, "pass did not wrap to the start")

endmodule

`default_nettype wire

FILE: rtl/vmm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vmm_back #(
    parameter int MAX_COLS = vmm_pkg::MAX_COLS_DEF,
    parameter int COL_W    = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    output logic                                     q_ready,
    input  wire logic signed [vmm_pkg::PROD_W-1:0]   q_prod,
    input  wire logic [COL_W-1:0]                    q_col,
    input  wire vmm_pkg::vmm_flags_t                 q_flags,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [vmm_pkg::SUM_W-1:0]         col_sum,
    output logic [vmm_pkg::IDX_W-1:0]                col_index,
    output logic                                     pass_last
);
    import vmm_pkg::*;

    `include "vector_matrix_multiply_assert.svh"

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_ACC  = 2'b10
    } vmm_bk_state_t;

    vmm_bk_state_t           state_reg;
    vmm_bk_state_t           state_next;
    logic signed [SUM_W-1:0] acc_mem [MAX_COLS];
    logic signed [SUM_W-1:0] rdata_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [COL_W-1:0]        col_reg;
    vmm_flags_t              flags_reg;
    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] col_sum_reg;
    logic [IDX_W-1:0]        col_index_reg;
    logic                    pass_last_reg;
    logic signed [SUM_W-1:0] sum;
    logic                    pop;
    logic                    out_free;
    logic                    done;

    assign q_ready  = (state_reg == BK_IDLE);
    assign pop      = q_valid && q_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign done     = (state_reg == BK_ACC) && (!flags_reg.last_row || out_free);
    assign sum      = flags_reg.first_row ? SUM_W'(prod_reg) : rdata_reg + SUM_W'(prod_reg);

    assign out_valid = out_valid_reg;
    assign col_sum   = col_sum_reg;
    assign col_index = col_index_reg;
    assign pass_last = pass_last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    state_next = BK_ACC;
                end
            end
            BK_ACC:
            begin
                if (done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (done && flags_reg.last_row)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_reg  <= q_prod;
            col_reg   <= q_col;
            flags_reg <= q_flags;
        end
        if (done && flags_reg.last_row)
        begin
            col_sum_reg   <= sum;
            col_index_reg <= IDX_W'(col_reg);
            pass_last_reg <= flags_reg.pass_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            acc_mem[col_reg] <= sum;
        end
        if (pop)
        begin
            rdata_reg <= acc_mem[q_col];
        end
    end

    `VMM_ASSERT(a_result_last_row, clk, rst_n, $rose(out_valid_reg) |-> $past(flags_reg.last_row), "result raised for an item that is not on the last row")

endmodule

`default_nettype wire
